/* rtl/stlm_pkg.sv */
// Package for the sorted two-list merge: opcodes, status codes, defaults and
// the control/status structs passed between the top level and each list.
// No dependencies.
package stlm_pkg;

   localparam int DEF_LIST_DEPTH  = 256;
   localparam int DEF_VALUE_WIDTH = 32;

   typedef enum logic [1:0] {
      OP_APPEND_A = 2'd0,
      OP_APPEND_B = 2'd1,
      OP_PULL     = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_DELIVERED = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_DROPPED   = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } lst_ctl_type;

   typedef struct packed {
      logic empty;
      logic single;
      logic full;
   } lst_sts_type;

endpackage

/* rtl/stlm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stlm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/stlm_list.sv */
// One bounded sorted list: circular store in a RAM with the head value held
// in a register and the entry after it prefetched every cycle.
// Depends on stlm_pkg and stlm_ram.
module stlm_list
   import stlm_pkg::*;
#(
   parameter int LIST_DEPTH  = DEF_LIST_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lst_ctl_type            ctl,
   input  logic [VALUE_WIDTH-1:0] push_value,
   output logic [VALUE_WIDTH-1:0] head_value,
   output lst_sts_type            sts
);

   localparam int PTR_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(LIST_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LIST_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   logic [PTR_W-1:0]       head_ff, head_in, tail_ff, tail_in, rd_addr;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [VALUE_WIDTH-1:0] hv_ff, hv_in, byp_val_ff, rd_data, nxt_val;
   logic                   byp_ff, byp_in;

   // rd_data holds the entry after the current head; a write to that entry
   // in the previous cycle is taken from the bypass register instead
   assign rd_addr = next_ptr(head_in);
   assign byp_in  = ctl.push && (tail_ff == rd_addr);
   assign nxt_val = byp_ff ? byp_val_ff : rd_data;

   always_comb begin
      head_in  = ctl.pop ? next_ptr(head_ff) : head_ff;
      tail_in  = ctl.push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
      priority if (ctl.push && count_ff == '0) begin
         hv_in = push_value;
      end else if (ctl.pop) begin
         hv_in = nxt_val;
      end else begin
         hv_in = hv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         byp_ff   <= byp_in;
      end
      hv_ff      <= hv_in;
      byp_val_ff <= push_value;
   end

   stlm_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail_ff),
      .wr_data (push_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign head_value = hv_ff;
   assign sts.empty  = (count_ff == '0);
   assign sts.single = (count_ff == ONE_CNT);
   assign sts.full   = (count_ff == FULL_CNT);

endmodule

/* rtl/sorted_two_list_merge.sv */
// Sorted two-list merge: two bounded lists loaded in non-decreasing order and
// pulled out as one stable merged stream. Depends on stlm_pkg and stlm_list.
//
// Takes one beat per clock cycle for every opcode whenever the result register
// is free or being drained; the result of a beat, if any, appears in the result
// register on the next cycle. The pull path is a signed compare of the two head
// registers and one pointer advance, with each list's RAM read one entry ahead
// of its head. No clearing pass after reset: list contents are tracked by head,
// tail and count only.
module sorted_two_list_merge
   import stlm_pkg::*;
#(
   parameter int LIST_DEPTH  = DEF_LIST_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // element_value
   input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   // opcode
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // merged_value
   output logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] rsp_tdata,
   // status
   output logic [1:0]                           rsp_tuser,
   // last_element
   output logic                                 rsp_tlast
);

   localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   op_type                 opcode;
   lst_ctl_type            ctl_a, ctl_b;
   lst_sts_type            sts_a, sts_b;
   logic [VALUE_WIDTH-1:0] head_a, head_b, push_value, val_in, rsp_value_ff;
   logic                   req_accept, both_empty, take_a, gen, last_in;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   status_type             sts_in, rsp_status_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign push_value = req_tdata[VALUE_WIDTH-1:0];
   assign opcode     = op_type'(req_tuser);
   assign both_empty = sts_a.empty && sts_b.empty;

   always_comb begin
      priority if (sts_a.empty) begin
         take_a = 1'b0;
      end else if (sts_b.empty) begin
         take_a = 1'b1;
      end else begin
         take_a = $signed(head_a) <= $signed(head_b);
      end
   end

   always_comb begin
      ctl_a   = '0;
      ctl_b   = '0;
      gen     = 1'b0;
      sts_in  = STS_DELIVERED;
      val_in  = '0;
      last_in = 1'b0;
      if (req_accept) begin
         unique case (opcode)
            OP_APPEND_A: begin
               if (sts_a.full) begin
                  gen    = 1'b1;
                  sts_in = STS_DROPPED;
               end else begin
                  ctl_a.push = 1'b1;
               end
            end
            OP_APPEND_B: begin
               if (sts_b.full) begin
                  gen    = 1'b1;
                  sts_in = STS_DROPPED;
               end else begin
                  ctl_b.push = 1'b1;
               end
            end
            OP_PULL: begin
               gen = 1'b1;
               priority if (both_empty) begin
                  sts_in = STS_EMPTY;
               end else if (take_a) begin
                  ctl_a.pop = 1'b1;
                  val_in    = head_a;
                  last_in   = sts_a.single && sts_b.empty;
               end else begin
                  ctl_b.pop = 1'b1;
                  val_in    = head_b;
                  last_in   = sts_b.single && sts_a.empty;
               end
            end
            default: begin
               gen = 1'b0;
            end
         endcase
      end
      rsp_valid_in = gen || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (gen) begin
         rsp_status_ff <= sts_in;
         rsp_value_ff  <= val_in;
         rsp_last_ff   <= last_in;
      end
   end

   stlm_list #(
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_list_a (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_a),
      .push_value (push_value),
      .head_value (head_a),
      .sts        (sts_a)
   );

   stlm_list #(
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_list_b (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_b),
      .push_value (push_value),
      .head_value (head_b),
      .sts        (sts_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/stlm_checker.sv */
// Port-level checks for the sorted two-list merge, bound to the top level.
// Depends on stlm_pkg and sorted_two_list_merge.
module stlm_checker
   import stlm_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] rsp_tdata,
   input logic [1:0]                           rsp_tuser,
   input logic                                 rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_last_delivered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == STS_DELIVERED)
      else $error("last flag on a status beat");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STS_DELIVERED |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("status beat carries data");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result beat without an accepted request");

endmodule

bind sorted_two_list_merge stlm_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (.*);

/* bench/sorted_two_list_merge_tb.sv */
`timescale 1ns / 100ps
// Testbench for sorted_two_list_merge: directed and random load/pull beats against
// a queue-based merge predictor, with random source idling and sink stalls.
// Depends on stlm_pkg and the sorted_two_list_merge RTL.
module sorted_two_list_merge_tb;
   import stlm_pkg::*;

   localparam int LIST_DEPTH = DEF_LIST_DEPTH;
   localparam int DATA_W     = ((DEF_VALUE_WIDTH + 7) / 8) * 8;
   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam longint VAL_MIN = -64'sd2147483648;
   localparam longint VAL_MAX = 64'sd2147483647;

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] value;
      logic              last;
   } merge_result_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;   // element_value
   logic [1:0]        req_tuser;   // opcode
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;   // merged_value
   logic [1:0]        rsp_tuser;   // status
   logic              rsp_tlast;   // last_element

   logic [DATA_W-1:0] list_a_q[$];
   logic [DATA_W-1:0] list_b_q[$];
   merge_result_type  pending_results[$];

   int idle_pct  = 20;
   int stall_pct = 20;
   int beats_sent, results_seen, delivered_count, empty_count, drop_count, err_count;

   sorted_two_list_merge u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic merge_model(input logic [1:0] op, input logic [DATA_W-1:0] value);
      merge_result_type r;
      logic             take_a;
      logic             has_result;
      r = '{STS_DELIVERED, '0, 1'b0};
      has_result = 1'b0;
      case (op)
         OP_APPEND_A: begin
            if (list_a_q.size() < LIST_DEPTH) list_a_q.push_back(value);
            else begin
               r.status = STS_DROPPED;
               has_result = 1'b1;
            end
         end
         OP_APPEND_B: begin
            if (list_b_q.size() < LIST_DEPTH) list_b_q.push_back(value);
            else begin
               r.status = STS_DROPPED;
               has_result = 1'b1;
            end
         end
         OP_PULL: begin
            has_result = 1'b1;
            if (list_a_q.size() == 0 && list_b_q.size() == 0) begin
               r.status = STS_EMPTY;
            end else begin
               // ties go to list A
               take_a = list_a_q.size() != 0 &&
                        (list_b_q.size() == 0 ||
                         $signed(list_a_q[0]) <= $signed(list_b_q[0]));
               r.value = take_a ? list_a_q.pop_front() : list_b_q.pop_front();
               r.last  = list_a_q.size() == 0 && list_b_q.size() == 0;
            end
         end
         default: ;
      endcase
      if (has_result) pending_results.push_back(r);
   endtask

   task automatic send_beat(input logic [1:0] op, input logic [DATA_W-1:0] value);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 2'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      merge_model(op, value);
      if (op != OP_RESERVED) beats_sent++;
   endtask

   task automatic check_result();
      merge_result_type exp_r;
      if (pending_results.size() == 0) begin
         $error("unexpected result beat: status %0d value %0h last %0b",
                rsp_tuser, rsp_tdata, rsp_tlast);
         err_count++;
         return;
      end
      exp_r = pending_results.pop_front();
      results_seen++;
      case (exp_r.status)
         STS_DELIVERED: delivered_count++;
         STS_EMPTY:     empty_count++;
         default:       drop_count++;
      endcase
      if (rsp_tuser != exp_r.status) begin
         $error("status: expected %0d, got %0d", exp_r.status, rsp_tuser);
         err_count++;
      end
      if (rsp_tdata !== exp_r.value) begin
         $error("merged_value: expected %0d, got %0d",
                $signed(exp_r.value), $signed(rsp_tdata));
         err_count++;
      end
      if (rsp_tlast !== exp_r.last) begin
         $error("last_element: expected %0b, got %0b", exp_r.last, rsp_tlast);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic longint first_value();
      case ($urandom_range(3))
         0:       return VAL_MIN + $urandom_range(0, 3);
         1:       return VAL_MAX - $urandom_range(0, 40);
         2:       return longint'($signed($urandom));
         default: return longint'($urandom_range(0, 20)) - 10;
      endcase
   endfunction

   function automatic longint next_sorted(input longint prev, input int spread);
      longint n;
      n = prev + $urandom_range(0, spread);
      return (n > VAL_MAX) ? VAL_MAX : n;
   endfunction

   task automatic test_empty_pull();
      send_beat(OP_PULL, '0);
      send_beat(OP_RESERVED, 32'hFFFF_FFFF);
      send_beat(OP_PULL, 32'hFFFF_FFFF);
   endtask

   task automatic test_extremes();
      send_beat(OP_APPEND_A, 32'h8000_0000);
      send_beat(OP_APPEND_B, 32'h8000_0000);
      send_beat(OP_APPEND_A, 32'hFFFF_FFFF);
      send_beat(OP_APPEND_B, 32'h0000_0000);
      send_beat(OP_APPEND_A, 32'h7FFF_FFFF);
      send_beat(OP_APPEND_B, 32'h7FFF_FFFF);
      repeat (7) send_beat(OP_PULL, $urandom);
   endtask

   // equal heads with list A out of order makes the tie order visible
   task automatic test_tie_order();
      send_beat(OP_APPEND_A, 32'd5);
      send_beat(OP_APPEND_A, 32'd1);
      send_beat(OP_APPEND_B, 32'd5);
      send_beat(OP_APPEND_B, 32'd9);
      repeat (5) send_beat(OP_PULL, '0);
   endtask

   task automatic test_full_lists();
      for (int i = 0; i < LIST_DEPTH; i++) send_beat(OP_APPEND_A, 2 * i - LIST_DEPTH);
      send_beat(OP_APPEND_A, 32'h7FFF_FFFF);
      for (int i = 0; i < LIST_DEPTH; i++) send_beat(OP_APPEND_B, 2 * i + 1 - LIST_DEPTH);
      send_beat(OP_APPEND_B, 32'h8000_0000);
      repeat (2 * LIST_DEPTH + 1) send_beat(OP_PULL, $urandom);
   endtask

   task automatic test_random_merges(input int n_items);
      int     start, len_a, len_b, spread, n_pull, total;
      longint val_a, val_b;
      start = beats_sent;
      while (beats_sent - start < n_items) begin
         idle_pct  = (beats_sent - start < 120) ? 0 : 20;
         stall_pct = idle_pct;
         if ($urandom_range(9) < 8) begin
            len_a  = $urandom_range(0, 14);
            len_b  = $urandom_range(0, 14);
            spread = ($urandom_range(3) == 0) ? 2 : ($urandom_range(1) ? 1000 : 1 << 30);
            val_a  = first_value();
            val_b  = first_value();
            while (len_a + len_b > 0) begin
               if (len_b == 0 || (len_a > 0 && $urandom_range(1))) begin
                  send_beat(OP_APPEND_A, val_a[DATA_W-1:0]);
                  val_a = next_sorted(val_a, spread);
                  len_a--;
               end else begin
                  send_beat(OP_APPEND_B, val_b[DATA_W-1:0]);
                  val_b = next_sorted(val_b, spread);
                  len_b--;
               end
            end
            total  = list_a_q.size() + list_b_q.size();
            n_pull = ($urandom_range(4) == 0) ? total / 2 : total + $urandom_range(0, 2);
            repeat (n_pull) send_beat(OP_PULL, $urandom);
         end else begin
            // noise: any opcode, unsorted values
            repeat ($urandom_range(1, 6)) send_beat(2'($urandom_range(3)), $urandom);
         end
      end
      idle_pct  = 20;
      stall_pct = 20;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_pull();
      test_extremes();
      test_tie_order();
      test_full_lists();
      test_random_merges(200);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d load/pull beats; checked %0d results", beats_sent, results_seen);
      $display("(%0d delivered, %0d empty pulls, %0d dropped loads)",
               delivered_count, empty_count, drop_count);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
